@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros: shared assertion macros for the rtl
// clocked property checks, with and without reset gating
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ hw/rtl/bjp_pkg.sv @@
// ----------------------------------------------------------------------------
// bjp_pkg
// types and constants shared by the bezier joint placer modules
// ----------------------------------------------------------------------------
package bjp_pkg;

  localparam int MAX_JOINTS_DEF = 64;
  localparam int RESULT_LIMIT   = 64;
  localparam int DIV_BITS       = 23;   // numerator width of (i << 17) + d
  localparam int STEP_LAST      = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSTART,
    ST_DWAIT,
    ST_MATH,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_UU,
    MUL_TU,
    MUL_TT,
    MUL_UUU,
    MUL_TUU,
    MUL_TTU,
    MUL_X0,
    MUL_Y0,
    MUL_X1,
    MUL_Y1,
    MUL_X2,
    MUL_Y2,
    MUL_X3,
    MUL_Y3
  } mul_sel_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_UU,
    DST_TU,
    DST_TT,
    DST_W0,
    DST_W1,
    DST_W2,
    DST_W3
  } dst_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic [5:0] idx;
    logic [5:0] d;
    mul_sel_t mul_sel;
    dst_t     dst;
    logic     acc_clr;
    logic     acc_x;
    logic     acc_y;
    logic     emit;
    logic     last;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ hw/rtl/bjp_divider.sv @@
// ----------------------------------------------------------------------------
// bjp_divider
// restoring divider, one quotient bit per cycle, for t = ((i<<17)+d)/(2d)
// ----------------------------------------------------------------------------
module bjp_divider
  import bjp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_BITS-1:0] num,
  input  logic [6:0]          den,
  output logic                done,
  output logic [16:0]         quot
);

  logic [DIV_BITS-1:0] work;
  logic [6:0]          rem;
  logic [4:0]          cnt;
  logic [7:0]          rs;
  logic                ge;

  assign rs   = {rem, work[DIV_BITS-1]};
  assign ge   = rs >= {1'b0, den};
  assign quot = work[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 5'(DIV_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= num;
      rem  <= '0;
    end else if (cnt != '0) begin
      rem  <= ge ? 7'(rs - {1'b0, den}) : rs[6:0];
      work <= {work[DIV_BITS-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/bjp_datapath.sv @@
// ----------------------------------------------------------------------------
// bjp_datapath
// point registers, shared multiplier, weights, accumulators, output register
// ----------------------------------------------------------------------------
module bjp_datapath
  import bjp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output dp_status_t         status,
  input  logic               command,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] ctrl_a_x,
  input  logic signed [31:0] ctrl_a_y,
  input  logic signed [31:0] ctrl_b_x,
  input  logic signed [31:0] ctrl_b_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         joint_index,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic               last
);

  logic signed [31:0] px [4];
  logic signed [31:0] py [4];
  logic               cubic;

  logic [DIV_BITS-1:0] num;
  logic                div_done;
  logic [16:0]         t;
  logic [16:0]         u;

  logic [32:0] uu, tu, tt;
  logic [32:0] w0, w1, w2, w3;

  logic signed [33:0] op_a;
  logic signed [32:0] op_b;
  logic signed [66:0] prod_full;
  logic signed [65:0] prod;
  logic [51:0]        prod3;
  logic [33:0]        w3c;

  logic signed [65:0] acc_x, acc_y;

  assign num = DIV_BITS'({cmd.idx, 17'b0}) + DIV_BITS'(cmd.d);

  bjp_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   ({cmd.d, 1'b0}),
    .done  (div_done),
    .quot  (t)
  );

  assign u = 17'h10000 - t;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cubic <= command;
      px[0] <= start_x;  py[0] <= start_y;
      px[1] <= ctrl_a_x; py[1] <= ctrl_a_y;
      px[2] <= ctrl_b_x; py[2] <= ctrl_b_y;
      px[3] <= end_x;    py[3] <= end_y;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MUL_UU:  begin op_a = {17'b0, u};  op_b = {16'b0, u}; end
      MUL_TU:  begin op_a = {17'b0, t};  op_b = {16'b0, u}; end
      MUL_TT:  begin op_a = {17'b0, t};  op_b = {16'b0, t}; end
      MUL_UUU: begin op_a = {1'b0, uu};  op_b = {16'b0, u}; end
      MUL_TUU: begin op_a = {1'b0, tu};  op_b = {16'b0, u}; end
      MUL_TTU: begin op_a = {1'b0, tt};  op_b = {16'b0, u}; end
      MUL_X0:  begin op_a = {1'b0, w0};  op_b = {px[0][31], px[0]}; end
      MUL_Y0:  begin op_a = {1'b0, w0};  op_b = {py[0][31], py[0]}; end
      MUL_X1:  begin op_a = {1'b0, w1};  op_b = {px[1][31], px[1]}; end
      MUL_Y1:  begin op_a = {1'b0, w1};  op_b = {py[1][31], py[1]}; end
      MUL_X2:  begin op_a = {1'b0, w2};  op_b = {px[2][31], px[2]}; end
      MUL_Y2:  begin op_a = {1'b0, w2};  op_b = {py[2][31], py[2]}; end
      MUL_X3:  begin op_a = {1'b0, w3};  op_b = {px[3][31], px[3]}; end
      MUL_Y3:  begin op_a = {1'b0, w3};  op_b = {py[3][31], py[3]}; end
      default: begin op_a = '0;          op_b = '0; end
    endcase
  end

  assign prod_full = op_a * op_b;
  assign prod3     = 52'({prod[49:0], 1'b0}) + 52'(prod[49:0]);
  assign w3c       = 34'h1_0000_0000 - {1'b0, w0} - {1'b0, w1} - {1'b0, w2};

  always_ff @(posedge clk) begin
    prod <= prod_full[65:0];
    case (cmd.dst)
      DST_UU: uu <= prod[32:0];
      DST_TU: tu <= prod[32:0];
      DST_TT: tt <= prod[32:0];
      DST_W0: w0 <= cubic ? prod[48:16] : uu;
      DST_W1: w1 <= cubic ? prod3[48:16] : {tu[31:0], 1'b0};
      DST_W2: w2 <= cubic ? prod3[48:16] : '0;
      DST_W3: w3 <= cubic ? w3c[32:0] : tt;
      default: ;
    endcase
    if (cmd.acc_clr) begin
      acc_x <= '0;
      acc_y <= '0;
    end else begin
      if (cmd.acc_x) acc_x <= acc_x + prod;
      if (cmd.acc_y) acc_y <= acc_y + prod;
    end
  end

  // round to nearest, ties up, then saturate to 32 bits
  function automatic logic [31:0] round_sat(input logic signed [65:0] a);
    logic signed [65:0] b;
    logic signed [33:0] r;
    b = a + 66'sh8000_0000;
    r = b[65:32];
    if (r > 34'sh0_7FFF_FFFF) begin
      round_sat = 32'h7FFF_FFFF;
    end else if (r < -34'sh0_8000_0000) begin
      round_sat = 32'h8000_0000;
    end else begin
      round_sat = r[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      joint_index <= cmd.idx;
      pos_x       <= round_sat(acc_x);
      pos_y       <= round_sat(acc_y);
      last        <= cmd.last;
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;

endmodule

@@ hw/rtl/bjp_ctrl.sv @@
// ----------------------------------------------------------------------------
// bjp_ctrl
// joint sequencer: config register, joint counter and micro-step schedule
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bjp_ctrl
  import bjp_pkg::*;
#(
  parameter int JOINT_LIMIT = RESULT_LIMIT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t     state, state_next;
  logic [6:0] joint_count;
  logic [6:0] n_eff;
  logic [6:0] n;
  logic [5:0] idx;
  logic [4:0] step;
  logic       take;
  logic       is_last;

  assign n_eff    = (joint_count > 7'(JOINT_LIMIT)) ? 7'(JOINT_LIMIT) : joint_count;
  assign in_stall = (state != ST_IDLE);
  assign take     = in_valid && (state == ST_IDLE);
  assign is_last  = ({1'b0, idx} == 7'(n - 7'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      joint_count <= '0;
      n           <= '0;
      idx         <= '0;
      step        <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) joint_count <= cfg_wr_data;
      if (take) begin
        n   <= n_eff;
        idx <= '0;
      end
      if (state == ST_DSTART) step <= '0;
      else if (state == ST_MATH) step <= step + 5'd1;
      if (state == ST_EMIT && status.out_free && !is_last) idx <= idx + 6'd1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (take && n_eff >= 7'd2) state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT:  if (status.div_done) state_next = ST_MATH;
      ST_MATH:   if (step == 5'(STEP_LAST)) state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) state_next = is_last ? ST_IDLE : ST_DSTART;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_NONE;
    cmd.dst       = DST_NONE;
    cmd.load      = take;
    cmd.idx       = idx;
    cmd.d         = 6'(n - 7'd1);
    cmd.last      = is_last;
    case (state)
      ST_DSTART: cmd.div_start = 1'b1;
      ST_MATH: begin
        // weights first, then products alternate x and y into the accumulators
        case (step)
          5'd0:  cmd.mul_sel = MUL_UU;
          5'd1:  begin cmd.mul_sel = MUL_TU;  cmd.dst = DST_UU; end
          5'd2:  begin cmd.mul_sel = MUL_TT;  cmd.dst = DST_TU; end
          5'd3:  begin cmd.mul_sel = MUL_UUU; cmd.dst = DST_TT; end
          5'd4:  begin cmd.mul_sel = MUL_TUU; cmd.dst = DST_W0; cmd.acc_clr = 1'b1; end
          5'd5:  begin cmd.mul_sel = MUL_TTU; cmd.dst = DST_W1; end
          5'd6:  cmd.dst = DST_W2;
          5'd7:  cmd.dst = DST_W3;
          5'd8:  cmd.mul_sel = MUL_X0;
          5'd9:  begin cmd.mul_sel = MUL_Y0; cmd.acc_x = 1'b1; end
          5'd10: begin cmd.mul_sel = MUL_X1; cmd.acc_y = 1'b1; end
          5'd11: begin cmd.mul_sel = MUL_Y1; cmd.acc_x = 1'b1; end
          5'd12: begin cmd.mul_sel = MUL_X2; cmd.acc_y = 1'b1; end
          5'd13: begin cmd.mul_sel = MUL_Y2; cmd.acc_x = 1'b1; end
          5'd14: begin cmd.mul_sel = MUL_X3; cmd.acc_y = 1'b1; end
          5'd15: begin cmd.mul_sel = MUL_Y3; cmd.acc_x = 1'b1; end
          5'd16: cmd.acc_y = 1'b1;
          default: ;
        endcase
      end
      ST_EMIT: cmd.emit = status.out_free;
      default: ;
    endcase
  end

  `ASSERT_CLK(a_emit_free, cmd.emit |-> status.out_free)
  `ASSERT_CLK(a_last_idle, (cmd.emit && cmd.last) |=> (state == ST_IDLE))
  `ASSERT_CLK(a_div_to_math, (state == ST_DWAIT && status.div_done) |=> (state == ST_MATH))
  `ASSERT_CLK(a_idx_range, (state != ST_IDLE) |-> ({1'b0, idx} < n))

endmodule

@@ hw/rtl/bezier_joint_placer.sv @@
// ----------------------------------------------------------------------------
// bezier_joint_placer
// uniform joint placement along a quadratic or cubic bezier curve
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid/in_stall, command, pts  | one curve per transfer
//  out     | out_valid/out_stall, joint data  | one joint per transfer
//  cfg     | cfg_wr_en, cfg_wr_data           | joint count write
//
// each joint runs through a divider start, a wait on the 23-step serial
// divide for t, 17 steps on the one shared multiplier (weights, then eight
// products) and an emit step. a curve is accepted while idle and its n
// joints then follow in turn; input is taken only when idle.
// reset (rst, synchronous) clears the joint count and the sequencer.
// a stalled output holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
module bezier_joint_placer
  import bjp_pkg::*;
#(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] ctrl_a_x,
  input  logic signed [31:0] ctrl_a_y,
  input  logic signed [31:0] ctrl_b_x,
  input  logic signed [31:0] ctrl_b_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         joint_index,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic               last
);

  localparam int JOINT_LIMIT = (MAX_JOINTS < RESULT_LIMIT) ? MAX_JOINTS : RESULT_LIMIT;

  ctl_cmd_t   cmd;
  dp_status_t status;

  bjp_ctrl #(
    .JOINT_LIMIT (JOINT_LIMIT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  bjp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .command     (command),
    .start_x     (start_x),
    .start_y     (start_y),
    .ctrl_a_x    (ctrl_a_x),
    .ctrl_a_y    (ctrl_a_y),
    .ctrl_b_x    (ctrl_b_x),
    .ctrl_b_y    (ctrl_b_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .joint_index (joint_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .last        (last)
  );

endmodule
